>>> rtl/cmpi_pkg.sv
// ----------------------------------------------------------------------------
// cmpi_pkg
// types, constants and the control store of the cascaded motor pi controller
// ----------------------------------------------------------------------------
package cmpi_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SPEED_P     = 3'd0;
	localparam logic [2:0] REG_SPEED_I     = 3'd1;
	localparam logic [2:0] REG_OUTER_P     = 3'd2;
	localparam logic [2:0] REG_INNER_P     = 3'd3;
	localparam logic [2:0] REG_INNER_I     = 3'd4;
	localparam logic [2:0] REG_SPEED_ILIM  = 3'd5;
	localparam logic [2:0] REG_INNER_ILIM  = 3'd6;
	localparam logic [2:0] REG_DRIVE_LIM   = 3'd7;

	// register reset values
	localparam logic [15:0] RST_SPEED_P    = 16'd3840;
	localparam logic [15:0] RST_SPEED_I    = 16'd0;
	localparam logic [15:0] RST_OUTER_P    = 16'd102;
	localparam logic [15:0] RST_INNER_P    = 16'd1536;
	localparam logic [15:0] RST_INNER_I    = 16'd0;
	localparam logic [14:0] RST_SPEED_ILIM = 15'd250;
	localparam logic [14:0] RST_INNER_ILIM = 15'd2500;
	localparam logic [14:0] RST_DRIVE_LIM  = 15'd9999;

	// turn wrap thresholds in encoder counts
	localparam logic signed [14:0] HALF_TURN = 15'sd4095;
	localparam logic signed [14:0] FULL_TURN = 15'sd8191;

	// inner loop error saturation, 2^40 in q.8
	localparam logic signed [58:0] ERR_LIM = 59'sd1 <<< 40;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	// program entry points and the last step of the control store
	localparam step_t ST_SPEED = 5'd0;
	localparam step_t ST_POS   = 5'd7;
	localparam step_t ST_LAST  = 5'd21;

	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_ESPD,    // e = speed goal - speed
		ALU_ANGLE,   // multi-turn angle update
		ALU_EOUT,    // e = angle goal - angle sum
		ALU_PMSPD,   // acc = prod - speed * 256
		ALU_ECLAMP,  // e = sat(acc, 2^40)
		ALU_P21,     // acc = prod << 21
		ALU_ADDP,    // acc += prod
		ALU_ISHR,    // acc = inner int + (acc / 256 toward zero)
		ALU_CLI,     // inner int = sat(acc)
		ALU_ADDI,    // acc += inner int
		ALU_SP8,     // acc = speed int + prod << 8
		ALU_P8S,     // acc = prod << 8 + speed int
		ALU_CLS,     // speed int = sat(acc)
		ALU_CLD,     // acc = sat(acc, drive limit)
		ALU_DRIVE    // output word from acc
	} alu_op_t;

	typedef enum logic [1:0] {
		MA_FULL,     // e low 34 bits
		MA_HI,       // e arithmetic shift right by 21
		MA_LO        // e low 21 bits, unsigned
	} mul_a_t;

	typedef enum logic [2:0] {
		G_SP,
		G_SI,
		G_OP,
		G_IP,
		G_II
	} gain_sel_t;

	typedef struct packed {
		alu_op_t   alu;
		logic      mul_en;
		mul_a_t    ma;
		gain_sel_t gs;
		logic      jmp_pos;
		step_t     target;
		logic      last;
	} uword_t;

	function automatic uword_t mk(input alu_op_t alu, input logic mul_en, input mul_a_t ma,
		input gain_sel_t gs, input logic jmp_pos, input step_t target, input logic last);
		uword_t w;
		w.alu     = alu;
		w.mul_en  = mul_en;
		w.ma      = ma;
		w.gs      = gs;
		w.jmp_pos = jmp_pos;
		w.target  = target;
		w.last    = last;
		return w;
	endfunction

	// control store: speed loop at 0..6, position loop at 7..21
	function automatic uword_t ucode(input step_t a);
		uword_t w;
		case (a)
			5'd0:    w = mk(ALU_ESPD,   1'b0, MA_FULL, G_SP, 1'b1, ST_POS,   1'b0);
			5'd1:    w = mk(ALU_NOP,    1'b1, MA_FULL, G_SI, 1'b0, ST_SPEED, 1'b0);
			5'd2:    w = mk(ALU_SP8,    1'b1, MA_FULL, G_SP, 1'b0, ST_SPEED, 1'b0);
			5'd3:    w = mk(ALU_CLS,    1'b0, MA_FULL, G_SP, 1'b0, ST_SPEED, 1'b0);
			5'd4:    w = mk(ALU_P8S,    1'b0, MA_FULL, G_SP, 1'b0, ST_SPEED, 1'b0);
			5'd5:    w = mk(ALU_CLD,    1'b0, MA_FULL, G_SP, 1'b0, ST_SPEED, 1'b0);
			5'd6:    w = mk(ALU_DRIVE,  1'b0, MA_FULL, G_SP, 1'b0, ST_SPEED, 1'b1);
			5'd7:    w = mk(ALU_ANGLE,  1'b0, MA_FULL, G_OP, 1'b0, ST_SPEED, 1'b0);
			5'd8:    w = mk(ALU_EOUT,   1'b0, MA_FULL, G_OP, 1'b0, ST_SPEED, 1'b0);
			5'd9:    w = mk(ALU_NOP,    1'b1, MA_FULL, G_OP, 1'b0, ST_SPEED, 1'b0);
			5'd10:   w = mk(ALU_PMSPD,  1'b0, MA_FULL, G_OP, 1'b0, ST_SPEED, 1'b0);
			5'd11:   w = mk(ALU_ECLAMP, 1'b0, MA_FULL, G_II, 1'b0, ST_SPEED, 1'b0);
			5'd12:   w = mk(ALU_NOP,    1'b1, MA_HI,   G_II, 1'b0, ST_SPEED, 1'b0);
			5'd13:   w = mk(ALU_P21,    1'b1, MA_LO,   G_II, 1'b0, ST_SPEED, 1'b0);
			5'd14:   w = mk(ALU_ADDP,   1'b0, MA_LO,   G_II, 1'b0, ST_SPEED, 1'b0);
			5'd15:   w = mk(ALU_ISHR,   1'b1, MA_HI,   G_IP, 1'b0, ST_SPEED, 1'b0);
			5'd16:   w = mk(ALU_CLI,    1'b0, MA_HI,   G_IP, 1'b0, ST_SPEED, 1'b0);
			5'd17:   w = mk(ALU_P21,    1'b1, MA_LO,   G_IP, 1'b0, ST_SPEED, 1'b0);
			5'd18:   w = mk(ALU_ADDP,   1'b0, MA_LO,   G_IP, 1'b0, ST_SPEED, 1'b0);
			5'd19:   w = mk(ALU_ADDI,   1'b0, MA_LO,   G_IP, 1'b0, ST_SPEED, 1'b0);
			5'd20:   w = mk(ALU_CLD,    1'b0, MA_LO,   G_IP, 1'b0, ST_SPEED, 1'b0);
			5'd21:   w = mk(ALU_DRIVE,  1'b0, MA_LO,   G_IP, 1'b0, ST_SPEED, 1'b1);
			default: w = mk(ALU_NOP,    1'b0, MA_FULL, G_SP, 1'b0, ST_SPEED, 1'b1);
		endcase
		return w;
	endfunction

	// symmetric saturation
	function automatic logic signed [58:0] sat(input logic signed [58:0] v,
		input logic signed [58:0] lim);
		logic signed [58:0] r;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		else
			r = v;
		return r;
	endfunction

endpackage

>>> rtl/cascaded_motor_pi_with_turn_count.sv
// ----------------------------------------------------------------------------
// cascaded_motor_pi_with_turn_count
// cascaded position / speed pi controller with multi-turn angle tracking
//
// one input word per control tick on the s_ group, one output word per tick
// on the m_ group (drive and multi-turn angle). gains and limits are written
// through cfg_we / cfg_idx / cfg_wdata; the user writes them only while the
// block is idle, which the block itself does not enforce. a microcoded
// sequencer steps through a small control store; each step drives one
// 34x17 multiplier and one wide adder / saturator. once a word is taken,
// the program runs. the speed loop program is 7 steps, the position loop
// program 16 (the shared entry step, then 15). the position loop is
// longer because the 42-bit inner error is multiplied in two halves.
// the output register frees s_tready as soon as the program ends: the next
// word is taken while a result still waits. if m_tready is low when the
// next result is due, the program holds on its last step.
// reset clears all loop state and restores the default gains and limits;
// no word is pending afterwards.
// ----------------------------------------------------------------------------
module cascaded_motor_pi_with_turn_count
	import cmpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// encoder_angle[12:0], measured_speed[28:13], speed_goal[44:29],
	// angle_goal[76:45], zero fill[79:77]
	input  logic [79:0] s_tdata,
	// position_mode[0], realign[1]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// drive[15:0], angle_total[47:16]
	output logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	// configuration registers
	logic [15:0] sp_gain_q, si_gain_q, op_gain_q, ip_gain_q, ii_gain_q;
	logic [14:0] slim_q, ilim_q, dlim_q;

	// sequencer
	logic  busy_q;
	step_t step_q;
	uword_t uw;
	logic  stall, run, in_acc;

	// latched input word
	logic [12:0]        ang_q;
	logic signed [15:0] spd_q, sgoal_q;
	logic signed [31:0] agoal_q;
	logic               pos_q;

	// loop state
	logic [31:0]        ang_acc_q;
	logic [12:0]        prev_q;
	logic signed [31:0] int_s_q, int_i_q;

	// datapath
	logic signed [41:0] e_q;
	logic signed [58:0] acc_q;
	logic signed [50:0] prod_q;
	logic signed [33:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [50:0] prod_d;
	logic [15:0]        gain;

	logic        m_tvalid_q;

	assign uw       = ucode(step_q);
	assign in_acc   = s_tvalid && s_tready;
	// hold on the last step while the previous word has not been taken
	assign stall    = busy_q && uw.last && m_tvalid_q && !m_tready;
	assign run      = busy_q && !stall;
	assign s_tready = !busy_q;
	assign m_tvalid = m_tvalid_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_gain_q <= RST_SPEED_P;
			si_gain_q <= RST_SPEED_I;
			op_gain_q <= RST_OUTER_P;
			ip_gain_q <= RST_INNER_P;
			ii_gain_q <= RST_INNER_I;
			slim_q    <= RST_SPEED_ILIM;
			ilim_q    <= RST_INNER_ILIM;
			dlim_q    <= RST_DRIVE_LIM;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SPEED_P:    sp_gain_q <= cfg_wdata;
				REG_SPEED_I:    si_gain_q <= cfg_wdata;
				REG_OUTER_P:    op_gain_q <= cfg_wdata;
				REG_INNER_P:    ip_gain_q <= cfg_wdata;
				REG_INNER_I:    ii_gain_q <= cfg_wdata;
				REG_SPEED_ILIM: slim_q    <= cfg_wdata[14:0];
				REG_INNER_ILIM: ilim_q    <= cfg_wdata[14:0];
				REG_DRIVE_LIM:  dlim_q    <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= ST_SPEED;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				step_q <= ST_SPEED;
			end else if (run) begin
				if (uw.last)
					busy_q <= 1'b0;
				else if (uw.jmp_pos && pos_q)
					step_q <= uw.target;
				else
					step_q <= step_q + 1'b1;
			end
			// output register: loaded at the end of a program, freed on take
			if (run && uw.last)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		case (uw.ma)
			MA_FULL: mul_a = e_q[33:0];
			MA_HI:   mul_a = {{13{e_q[41]}}, e_q[41:21]};
			MA_LO:   mul_a = {13'b0, e_q[20:0]};
			default: mul_a = e_q[33:0];
		endcase
		case (uw.gs)
			G_SP:    gain = sp_gain_q;
			G_SI:    gain = si_gain_q;
			G_OP:    gain = op_gain_q;
			G_IP:    gain = ip_gain_q;
			G_II:    gain = ii_gain_q;
			default: gain = sp_gain_q;
		endcase
		mul_b = {1'b0, gain};
	end

	assign prod_d = mul_a * mul_b;

	// ---------------- loop state: angle sum and integrators ----------------
	logic signed [13:0] ang_d;
	logic signed [14:0] ang_x, ang_w;
	logic signed [58:0] lim_s59, lim_i59, sat_s, sat_i;

	always_comb begin
		ang_d = $signed({1'b0, ang_q}) - $signed({1'b0, prev_q});
		ang_x = {ang_d[13], ang_d};
		// a jump of half a turn or more counts as a wrap
		if (ang_x > HALF_TURN)
			ang_w = ang_x - FULL_TURN;
		else if (ang_x < -HALF_TURN)
			ang_w = ang_x + FULL_TURN;
		else
			ang_w = ang_x;
		lim_s59 = {28'b0, slim_q, 16'b0};
		lim_i59 = {28'b0, ilim_q, 16'b0};
		sat_s   = sat(acc_q, lim_s59);
		sat_i   = sat(acc_q, lim_i59);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_acc_q <= '0;
			prev_q    <= '0;
			int_s_q   <= '0;
			int_i_q   <= '0;
		end else if (in_acc) begin
			// realign takes effect before the loop of the same tick
			if (s_tuser[1]) begin
				ang_acc_q <= {19'b0, s_tdata[12:0]};
				prev_q    <= s_tdata[12:0];
				int_s_q   <= '0;
				int_i_q   <= '0;
			end
		end else if (run) begin
			case (uw.alu)
				ALU_ANGLE: begin
					ang_acc_q <= ang_acc_q + {{17{ang_w[14]}}, ang_w};
					prev_q    <= ang_q;
				end
				ALU_CLS: int_s_q <= sat_s[31:0];
				ALU_CLI: int_i_q <= sat_i[31:0];
				default: ;
			endcase
		end
	end

	// ---------------- datapath ----------------
	logic signed [58:0] prod59, int_s59, int_i59, tz8, tz16, lim_d59, err_sat;

	always_comb begin
		prod59  = {{8{prod_q[50]}}, prod_q};
		int_s59 = {{27{int_s_q[31]}}, int_s_q};
		int_i59 = {{27{int_i_q[31]}}, int_i_q};
		lim_d59 = {28'b0, dlim_q, 16'b0};
		err_sat = sat(acc_q, ERR_LIM);
		// round toward zero ahead of the arithmetic shifts
		tz8     = acc_q + (acc_q[58] ? 59'sd255 : 59'sd0);
		tz16    = acc_q + (acc_q[58] ? 59'sd65535 : 59'sd0);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ang_q   <= s_tdata[12:0];
			spd_q   <= s_tdata[28:13];
			sgoal_q <= s_tdata[44:29];
			agoal_q <= s_tdata[76:45];
			pos_q   <= s_tuser[0];
		end
		if (run && uw.mul_en)
			prod_q <= prod_d;
		if (run) begin
			case (uw.alu)
				ALU_ESPD:   e_q   <= {{26{sgoal_q[15]}}, sgoal_q} - {{26{spd_q[15]}}, spd_q};
				ALU_EOUT:   e_q   <= {{10{agoal_q[31]}}, agoal_q}
					- {{10{ang_acc_q[31]}}, ang_acc_q};
				ALU_PMSPD:  acc_q <= prod59 - {{35{spd_q[15]}}, spd_q, 8'b0};
				ALU_ECLAMP: e_q   <= err_sat[41:0];
				ALU_P21:    acc_q <= {prod_q[37:0], 21'b0};
				ALU_ADDP:   acc_q <= acc_q + prod59;
				ALU_ISHR:   acc_q <= int_i59 + (tz8 >>> 8);
				ALU_ADDI:   acc_q <= acc_q + int_i59;
				ALU_SP8:    acc_q <= int_s59 + {prod_q, 8'b0};
				ALU_P8S:    acc_q <= {prod_q, 8'b0} + int_s59;
				ALU_CLD:    acc_q <= sat(acc_q, lim_d59);
				ALU_DRIVE:  m_tdata <= {ang_acc_q, tz16[31:16]};
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a taken word always starts the program at its entry
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (busy_q && step_q == ST_SPEED))
		else $error("program did not start after input word");

	// the step counter stays inside the control store
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= ST_LAST))
		else $error("step counter out of range");

	// a new result only appears at the end of a program
	a_rose_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(busy_q && uw.last))
		else $error("result word without finished program");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> $stable(m_tdata))
		else $error("pending result overwritten");

	// drive stays within the saturation limit
	a_drive_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(run && uw.last) |=> ($signed(m_tdata[15:0]) <= $signed({1'b0, $past(dlim_q)})
			&& $signed(m_tdata[15:0]) >= -$signed({1'b0, $past(dlim_q)})))
		else $error("drive beyond limit");
`endif

endmodule
